// File: hdl/shell_command_tokenizer_macros.svh
// assertion macros for the shell command tokenizer
`ifndef SHELL_COMMAND_TOKENIZER_MACROS_SVH
`define SHELL_COMMAND_TOKENIZER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SCT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sct_pkg.sv
// package with codes, character constants and types of the shell command tokenizer
`default_nettype none
package sct_pkg;

  localparam int unsigned TokenBytesMaxDef = 256;
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned ResultsMax = 3;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SQUOTE = 3'd1,
    MODE_DQUOTE = 3'd2,
    MODE_DQ_ESC = 3'd3,
    MODE_ESC    = 3'd4,
    MODE_GT     = 3'd5,
    MODE_DONE   = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    KIND_BYTE   = 3'd0,
    KIND_WEND   = 3'd1,
    KIND_PIPE   = 3'd2,
    KIND_IN     = 3'd3,
    KIND_OUT    = 3'd4,
    KIND_APPEND = 3'd5,
    KIND_BG     = 3'd6,
    KIND_END    = 3'd7
  } kind_e;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChVt    = 8'h0b;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDquo  = 8'h22;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSquo  = 8'h27;
  localparam logic [7:0] ChLt    = 8'h3c;
  localparam logic [7:0] ChGt    = 8'h3e;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChPipe  = 8'h7c;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } tok_t;

endpackage
`default_nettype wire

// File: hdl/shell_command_tokenizer.sv
// top level of the shell command tokenizer: lexer stage and result queue
// an accepted byte passes the input register and the result queue to the output
// throughput: one byte per cycle while results are taken as fast as they come;
//   the output moves one result per cycle, so bytes that cause several results
//   stall the input once the 8-entry result queue has fewer than 3 free slots
// reset: asynchronous, active low; clears lexer mode, word byte count and queue
`default_nettype none
`include "shell_command_tokenizer_macros.svh"
module shell_command_tokenizer
  import sct_pkg::*;
#(
  parameter int unsigned TOKEN_BYTES_MAX = TokenBytesMaxDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output      logic [7:0] m_axis_tdata,   // [7:0] word_byte
  output      logic [2:0] m_axis_tuser,   // [2:0] token_kind
  output      logic       m_axis_tlast
);

  localparam int unsigned CntW = (TOKEN_BYTES_MAX > 2) ? $clog2(TOKEN_BYTES_MAX) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(TOKEN_BYTES_MAX - 1);
  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam logic [PtrW:0] FillLimit = (PtrW+1)'(FifoDepth - ResultsMax);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  // lexer state
  mode_e          mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // result queue
  tok_t          mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   fill_q, fill_d;

  logic       proc;
  logic       pop;
  tok_t       slot [ResultsMax];
  logic [1:0] n_res;

  assign proc = in_valid_q && (fill_q <= FillLimit);
  assign pop = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !in_valid_q || proc;
  assign in_valid_d = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !proc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // decode of one byte
  always_comb begin
    logic       pre_v;
    kind_e      pre_k;
    logic       acc_v;
    logic [7:0] acc_b;
    logic       fl_v;
    logic       op_v;
    kind_e      op_k;
    logic       run_norm;
    logic [CntW-1:0] cnt_a;
    logic [7:0] c;

    c = in_byte_q;
    pre_v = 1'b0;
    pre_k = KIND_OUT;
    acc_v = 1'b0;
    acc_b = c;
    fl_v = 1'b0;
    op_v = 1'b0;
    op_k = KIND_END;
    run_norm = 1'b0;
    mode_d = mode_q;

    unique case (mode_q)
      MODE_SQUOTE: begin
        if (c == ChNul) begin
          fl_v = 1'b1;
          op_v = 1'b1;
          mode_d = MODE_NORMAL;
        end else if (c == ChSquo) begin
          mode_d = MODE_NORMAL;
        end else begin
          acc_v = 1'b1;
        end
      end
      MODE_DQUOTE: begin
        if (c == ChNul) begin
          fl_v = 1'b1;
          op_v = 1'b1;
          mode_d = MODE_NORMAL;
        end else if (c == ChDquo) begin
          mode_d = MODE_NORMAL;
        end else if (c == ChBslash) begin
          mode_d = MODE_DQ_ESC;
        end else begin
          acc_v = 1'b1;
        end
      end
      MODE_DQ_ESC: begin
        acc_v = 1'b1;
        if (c == ChNul) begin
          acc_b = ChBslash;
          fl_v = 1'b1;
          op_v = 1'b1;
          mode_d = MODE_NORMAL;
        end else begin
          mode_d = MODE_DQUOTE;
        end
      end
      MODE_ESC: begin
        mode_d = MODE_NORMAL;
        if (c == ChNul) begin
          fl_v = 1'b1;
          op_v = 1'b1;
        end else begin
          acc_v = 1'b1;
        end
      end
      MODE_GT: begin
        pre_v = 1'b1;
        if (c == ChGt) begin
          pre_k = KIND_APPEND;
          mode_d = MODE_NORMAL;
        end else begin
          run_norm = 1'b1;
        end
      end
      MODE_DONE: begin
        if (c == ChNul) begin
          mode_d = MODE_NORMAL;
        end
      end
      default: begin
        run_norm = 1'b1;
      end
    endcase

    if (run_norm) begin
      mode_d = MODE_NORMAL;
      priority case (c)
        ChNul: begin
          fl_v = 1'b1;
          op_v = 1'b1;
        end
        ChLf: begin
          fl_v = 1'b1;
          op_v = 1'b1;
          mode_d = MODE_DONE;
        end
        ChSpace, ChTab, ChCr, ChVt, ChFf: fl_v = 1'b1;
        ChPipe: begin
          fl_v = 1'b1;
          op_v = 1'b1;
          op_k = KIND_PIPE;
        end
        ChLt: begin
          fl_v = 1'b1;
          op_v = 1'b1;
          op_k = KIND_IN;
        end
        ChAmp: begin
          fl_v = 1'b1;
          op_v = 1'b1;
          op_k = KIND_BG;
        end
        ChGt: begin
          fl_v = 1'b1;
          mode_d = MODE_GT;
        end
        ChSquo: mode_d = MODE_SQUOTE;
        ChDquo: mode_d = MODE_DQUOTE;
        ChBslash: mode_d = MODE_ESC;
        default: acc_v = 1'b1;
      endcase
    end

    // pack results into slots in emission order
    for (int i = 0; i < ResultsMax; i++) begin
      slot[i] = '{kind: KIND_END, data: 8'h00, last: 1'b0};
    end
    n_res = 2'd0;
    cnt_a = cnt_q;
    if (pre_v) begin
      slot[n_res] = '{kind: pre_k, data: 8'h00, last: 1'b0};
      n_res = n_res + 2'd1;
    end
    if (acc_v && (cnt_q != CntMax)) begin
      slot[n_res] = '{kind: KIND_BYTE, data: acc_b, last: 1'b0};
      n_res = n_res + 2'd1;
      cnt_a = cnt_q + CntW'(1);
    end
    cnt_d = cnt_a;
    if (fl_v) begin
      if (cnt_a != '0) begin
        slot[n_res] = '{kind: KIND_WEND, data: 8'h00, last: 1'b0};
        n_res = n_res + 2'd1;
      end
      cnt_d = '0;
    end
    if (op_v) begin
      slot[n_res] = '{kind: op_k, data: 8'h00, last: 1'b0};
      n_res = n_res + 2'd1;
    end
    if (n_res != 2'd0) begin
      slot[n_res - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      cnt_q <= '0;
    end else if (proc) begin
      mode_q <= mode_d;
      cnt_q <= cnt_d;
    end
  end

  // result queue
  always_comb begin
    fill_d = fill_q;
    if (proc) begin
      fill_d = fill_d + (PtrW+1)'(n_res);
    end
    if (pop) begin
      fill_d = fill_d - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (proc) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ResultsMax; i++) begin
      if (proc && (2'(i) < n_res)) begin
        mem_q[wr_ptr_q + PtrW'(i)] <= slot[i];
      end
    end
  end

  assign m_axis_tvalid = (fill_q != '0);
  assign m_axis_tdata = mem_q[rd_ptr_q].data;
  assign m_axis_tuser = mem_q[rd_ptr_q].kind;
  assign m_axis_tlast = mem_q[rd_ptr_q].last;

  `SCT_ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= (PtrW+1)'(FifoDepth), "result queue overrun")
  `SCT_ASSERT_SAME(a_done_silent, proc && (mode_q == MODE_DONE), n_res == 2'd0,
                   "result produced after newline")
  `SCT_ASSERT_NEXT(a_nul_resets, proc && (in_byte_q == ChNul),
                   (mode_q == MODE_NORMAL) && (cnt_q == '0), "line end did not reset lexer")

endmodule
`default_nettype wire
